// ===== src/http_response_header_scanner_assert.svh =====
// Assertion macros for the HTTP response header scanner.
`ifndef HTTP_RESPONSE_HEADER_SCANNER_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_SCANNER_ASSERT_SVH
`ifndef SYNTH
`define HRS_ASSERT_IMPL(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define HRS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define HRS_ASSERT_IMPL(label, clk, rst_n, cond)
`define HRS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== src/hrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types and constants of the header scanner.
// ----------------------------------------------------------------------------
package hrs_pkg;
	localparam int COUNT_BITS_DEF = 32;
	localparam int QUEUE_DEPTH = 2;

	// item passed from the front to the back
	typedef struct packed {
		logic [7:0] ch;
		logic       restart;
	} hrs_item_t;

	typedef enum logic [1:0] {
		NUM_SKIP = 2'd0,
		NUM_SIGN = 2'd1,
		NUM_DIGIT = 2'd2,
		NUM_DONE = 2'd3
	} num_phase_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
		return r;
	endfunction

	function automatic logic [7:0] clen_chr(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "c"; 4'd1: r = "o"; 4'd2: r = "n"; 4'd3: r = "t";
			4'd4: r = "e"; 4'd5: r = "n"; 4'd6: r = "t"; 4'd7: r = "-";
			4'd8: r = "l"; 4'd9: r = "e"; 4'd10: r = "n"; 4'd11: r = "g";
			4'd12: r = "t"; 4'd13: r = "h";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] conn_chr(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "c"; 4'd1: r = "o"; 4'd2: r = "n"; 4'd3: r = "n";
			4'd4: r = "e"; 4'd5: r = "c"; 4'd6: r = "t"; 4'd7: r = "i";
			4'd8: r = "o"; 4'd9: r = "n";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] keep_chr(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "k"; 4'd1: r = "e"; 4'd2: r = "e"; 4'd3: r = "p";
			4'd4: r = "-"; 4'd5: r = "a"; 4'd6: r = "l"; 4'd7: r = "i";
			4'd8: r = "v"; 4'd9: r = "e";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] close_chr(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = "c"; 3'd1: r = "l"; 3'd2: r = "o"; 3'd3: r = "s";
			3'd4: r = "e";
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage

// ===== src/hrs_queue.sv =====
// ----------------------------------------------------------------------------
// hrs_queue
// Small FIFO between the front and the back; each side stalls on its own.
// ----------------------------------------------------------------------------
module hrs_queue import hrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hrs_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output hrs_item_t out_item
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	hrs_item_t       mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            wr, rd;

	assign in_ready  = (cnt_q != (AW+1)'(QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rp_q];
	assign wr = in_valid & in_ready;
	assign rd = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_item;
	end
endmodule

// ===== src/hrs_back.sv =====
// ----------------------------------------------------------------------------
// hrs_back
// Per-byte scanner state; one byte per cycle into an output register unless out_ready stalls it.
// ----------------------------------------------------------------------------
module hrs_back import hrs_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  hrs_item_t          item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               in_body,
	output logic signed [31:0] length_value,
	output logic               persistent,
	output logic [31:0]        bytes_seen
);
	logic                  body_q, keep_q, close_q;
	logic [1:0]            nl_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [31:0]           len_q;
	logic                  nonempty_q, colon_q, nul_q, neg_q, kfound_q, cfound_q;
	logic [3:0]            pos_q, km_q;
	logic [2:0]            cm_q;
	logic [1:0]            cand_q;
	num_phase_t            ph_q;
	logic [31:0]           acc_q;
	logic                  vld_q;

	logic                  take;
	assign item_ready = !vld_q || out_ready;
	assign take = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			body_q <= 1'b0; keep_q <= 1'b0; close_q <= 1'b0; nl_q <= '0;
			cnt_q <= '0; len_q <= '1;
			nonempty_q <= 1'b0; colon_q <= 1'b0; nul_q <= 1'b0; neg_q <= 1'b0;
			kfound_q <= 1'b0; cfound_q <= 1'b0; pos_q <= '0; km_q <= '0; cm_q <= '0;
			cand_q <= 2'b11; ph_q <= NUM_SKIP; acc_q <= '0;
		end else begin
			if (out_valid && out_ready && !take) vld_q <= 1'b0;
			if (take) begin
				logic                  b, k, cl, ne, co, nu, ng, kf, cf;
				logic [1:0]            nl, cd;
				logic [COUNT_BITS-1:0] cn;
				logic [31:0]           ln, ac;
				logic [3:0]            ps, km;
				logic [2:0]            cm;
				num_phase_t            ph;
				logic [7:0]            c, f;
				logic                  dig;
				logic [35:0]           v;
				b = body_q; k = keep_q; cl = close_q; nl = nl_q; cn = cnt_q; ln = len_q;
				ne = nonempty_q; co = colon_q; nu = nul_q; ng = neg_q; kf = kfound_q;
				cf = cfound_q; ps = pos_q; km = km_q; cm = cm_q; cd = cand_q;
				ph = ph_q; ac = acc_q;
				c = item.ch;
				f = fold(c);
				dig = (f >= "0") && (f <= "9");
				v = {4'd0, acc_q} * 36'd10 + {28'd0, f - 8'h30};
				if (item.restart) begin
					b = 1'b0; k = 1'b0; cl = 1'b0; nl = '0; cn = '0; ln = '1;
					ne = 1'b0; co = 1'b0; nu = 1'b0; ng = 1'b0; kf = 1'b0; cf = 1'b0;
					ps = '0; km = '0;
					cm = '0; cd = 2'b11; ph = NUM_SKIP; ac = '0;
					v = {28'd0, f - 8'h30};
				end
				if (cn != '1) cn = cn + 1'b1;
				if (!b) begin
					if (c == 8'h0D || c == 8'h0A) begin
						if (ne) begin
							if (co) begin
								if (cd[0]) begin
									if (ng) ln = 32'd0 - ac;
									else ln = ac[31] ? 32'h7FFFFFFF : ac;
								end else if (cd[1]) begin
									if (kf) k = 1'b1;
									else if (cf) cl = 1'b1;
								end
							end
							ne = 1'b0; co = 1'b0; nu = 1'b0; ng = 1'b0; kf = 1'b0;
							cf = 1'b0; ps = '0;
							km = '0; cm = '0; cd = 2'b11; ph = NUM_SKIP; ac = '0;
						end
						if (c == 8'h0A) begin
							if (nl != 2'd3) nl = nl + 1'b1;
							if (nl >= 2'd2) b = 1'b1;
						end
					end else begin
						nl = '0;
						ne = 1'b1;
						if (!nu) begin
							if (c == 8'h00) nu = 1'b1;
							else if (!co) begin
								if (c == ":") begin
									co = 1'b1;
									if (ps != 4'd14) cd[0] = 1'b0;
									if (ps != 4'd10) cd[1] = 1'b0;
								end else begin
									if (!(ps < 4'd14 && f == clen_chr(ps))) cd[0] = 1'b0;
									if (!(ps < 4'd10 && f == conn_chr(ps))) cd[1] = 1'b0;
									if (ps != 4'd15) ps = ps + 1'b1;
								end
							end else begin
								case (ph)
									NUM_SKIP: begin
										if (f inside {8'h20, 8'h09, 8'h0B, 8'h0C}) begin
										end else if (f == "+" || f == "-") begin
											ng = (f == "-");
											ph = NUM_SIGN;
										end else if (dig) begin
											ac = {28'd0, f[3:0]};
											ph = NUM_DIGIT;
										end else ph = NUM_DONE;
									end
									NUM_SIGN, NUM_DIGIT: begin
										if (dig) begin
											ac = (v > 36'h80000000) ? 32'h80000000 : v[31:0];
											ph = NUM_DIGIT;
										end else ph = NUM_DONE;
									end
									default: ;
								endcase
								if (km < 4'd10 && f == keep_chr(km)) km = km + 1'b1;
								else km = (f == "k") ? 4'd1 : 4'd0;
								if (km >= 4'd10) begin kf = 1'b1; km = '0; end
								if (cm < 3'd5 && f == close_chr(cm)) cm = cm + 1'b1;
								else cm = (f == "c") ? 3'd1 : 3'd0;
								if (cm >= 3'd5) begin cf = 1'b1; cm = '0; end
							end
						end
					end
				end
				body_q <= b; keep_q <= k; close_q <= cl; nl_q <= nl; cnt_q <= cn;
				len_q <= ln; nonempty_q <= ne; colon_q <= co; nul_q <= nu; neg_q <= ng;
				kfound_q <= kf; cfound_q <= cf; pos_q <= ps; km_q <= km; cm_q <= cm;
				cand_q <= cd; ph_q <= ph; acc_q <= ac;
				vld_q <= 1'b1;
			end
		end
	end

	assign out_valid    = vld_q;
	assign in_body      = body_q;
	assign length_value = len_q;
	assign persistent   = keep_q & ~close_q;
	generate
		if (COUNT_BITS > 32) begin : g_sat
			assign bytes_seen = (|cnt_q[COUNT_BITS-1:32]) ? 32'hFFFFFFFF : cnt_q[31:0];
		end else begin : g_ext
			assign bytes_seen = 32'(cnt_q);
		end
	endgenerate
endmodule

// ===== src/hrs_front.sv =====
// ----------------------------------------------------------------------------
// hrs_front
// Input stage: registers one transfer and marks restart items.
// ----------------------------------------------------------------------------
module hrs_front import hrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] byte_in,
	input  logic      restart,
	output logic      item_valid,
	input  logic      item_ready,
	output hrs_item_t item
);
	logic      vld_s1;
	hrs_item_t item_s1;
	assign in_ready = !vld_s1 || item_ready;
	assign item_valid = vld_s1;
	assign item = item_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (in_ready) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= '{ch: byte_in, restart: restart};
	end
endmodule

// ===== src/http_response_header_scanner.sv =====
// Path: each result is registered in the front register, then a queue entry,
// then the scanner output register.
// Throughput: one byte per cycle while the output is not stalled.
// Either side may stall independently through the two-entry queue.
// Reset (arst_n low, asynchronous) empties all stages and puts the scanner
// in header phase with content length -1 and no marks.
// ----------------------------------------------------------------------------
// http_response_header_scanner
// Scans an HTTP response header byte by byte and reports status per byte.
// ----------------------------------------------------------------------------
`include "http_response_header_scanner_assert.svh"
module http_response_header_scanner import hrs_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         byte_in,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               in_body,
	output logic signed [31:0] length_value,
	output logic               persistent,
	output logic [31:0]        bytes_seen
);
	// front -> queue -> back
	logic      f_valid, f_ready, q_valid, q_ready;
	hrs_item_t f_item, q_item;

	hrs_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .byte_in, .restart,
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	hrs_queue u_queue (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	hrs_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
		.out_valid, .out_ready, .in_body, .length_value, .persistent, .bytes_seen
	);

	// a result waiting on a stall holds its value
	`HRS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, $stable(bytes_seen))
	// once in body, only a restart can leave it
	`HRS_ASSERT_NEXT(a_body, clk, arst_n, in_body && !(q_valid && q_ready && q_item.restart), in_body)
	// restart transfer gives a count of one
	`HRS_ASSERT_NEXT(a_rst, clk, arst_n, q_valid && q_ready && q_item.restart, bytes_seen == 32'd1)
endmodule

// ===== dv/tb_http_response_header_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_http_response_header_scanner
// Drives response byte streams into the header scanner: a short table of
// corner bytes, then random responses built from status lines, header lines
// (content-length, connection, others, broken ones) and body bytes. A scoreboard
// model of the scanner predicts the status after every byte, and each output
// transfer is checked field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_http_response_header_scanner;
	timeunit 1ns;
	timeprecision 1ps;
	import hrs_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         byte_in;
	logic               restart;
	logic               out_valid;
	logic               out_ready;
	logic               in_body;
	logic signed [31:0] length_value;
	logic               persistent;
	logic [31:0]        bytes_seen;

	http_response_header_scanner dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready),
		.in_body(in_body), .length_value(length_value), .persistent(persistent),
		.bytes_seen(bytes_seen)
	);

	// status reported after one byte
	typedef struct {
		bit                 body;
		logic signed [31:0] clen;
		bit                 persist;
		logic [31:0]        count;
	} status_t;

	// directed row: byte, restart, and an optional hand-typed status
	typedef struct {
		logic [7:0] ch;
		bit         rst;
		bit         typed;
		status_t    st;
	} row_t;

	status_t    status_q[$];  // expected status, oldest first
	int         errors = 0;
	int         bytes_sent = 0;
	int         lines_made = 0;
	int         responses = 0;
	bit         calm = 0;     // no idling on either side while set
	bit         drive_typed = 0;
	status_t    drive_status;
	logic [8:0] stream_q[$];  // {restart, byte} waiting to be sent

	// ---- scanner model state ----
	bit          m_body, m_keep, m_close;
	logic [1:0]  m_lf;
	logic [31:0] m_count;
	logic [31:0] m_clen;
	bit          m_nonempty, m_colon, m_nul;
	logic [3:0]  m_pos;
	logic [1:0]  m_cand;      // bit0 content-length, bit1 connection
	num_phase_t  m_nphase;
	bit          m_neg;
	logic [31:0] m_acc;
	logic [3:0]  m_keep_m;
	logic [3:0]  m_close_m;
	bit          m_keep_line, m_close_line;

	string CLEN_S  = "content-length";
	string CONN_S  = "connection";
	string KEEP_S  = "keep-alive";
	string CLOSE_S = "close";

	task automatic clear_line_state();
		m_nonempty = 0; m_colon = 0; m_nul = 0; m_pos = 0; m_cand = 2'b11;
		m_nphase = NUM_SKIP; m_neg = 0; m_acc = 0;
		m_keep_m = 0; m_close_m = 0; m_keep_line = 0; m_close_line = 0;
	endtask

	task automatic clear_scanner();
		m_body = 0; m_lf = 0; m_count = 0; m_clen = 32'hFFFF_FFFF;
		m_keep = 0; m_close = 0;
		clear_line_state();
	endtask

	// substring search step; restarts on the first pattern char
	function automatic logic [3:0] match_next(input logic [3:0] m, input logic [7:0] c,
			input string pat, inout bit found);
		if (m < pat.len() && c == pat[m]) m++;
		else m = (c == pat[0]) ? 4'd1 : 4'd0;
		if (m >= pat.len()) begin
			found = 1;
			m = 0;
		end
		return m;
	endfunction

	task automatic value_char(input logic [7:0] c);
		bit         dig;
		logic [63:0] v;
		dig = (c >= "0" && c <= "9");
		if (m_nphase == NUM_SKIP) begin
			if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
			end else if (c == "+" || c == "-") begin
				m_neg = (c == "-");
				m_nphase = NUM_SIGN;
			end else if (dig) begin
				m_acc = c - "0";
				m_nphase = NUM_DIGIT;
			end else
				m_nphase = NUM_DONE;
		end else if (m_nphase != NUM_DONE) begin
			if (dig) begin
				v = 64'(m_acc) * 10 + (c - "0");
				if (v > 64'h8000_0000) v = 64'h8000_0000;
				m_acc = v[31:0];
				m_nphase = NUM_DIGIT;
			end else
				m_nphase = NUM_DONE;
		end
		m_keep_m  = match_next(m_keep_m, c, KEEP_S, m_keep_line);
		m_close_m = match_next(m_close_m, c, CLOSE_S, m_close_line);
	endtask

	task automatic end_line();
		if (m_colon) begin
			if (m_cand[0]) begin
				if (m_neg) m_clen = 32'd0 - m_acc;
				else m_clen = (m_acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_acc;
			end else if (m_cand[1]) begin
				if (m_keep_line) m_keep = 1;
				else if (m_close_line) m_close = 1;
			end
		end
		clear_line_state();
	endtask

	// advance the model by one byte and return the status it reports
	task automatic scan_byte(input logic [7:0] c, input bit rst, output status_t st);
		logic [7:0] f;
		if (rst) clear_scanner();
		if (m_count != 32'hFFFF_FFFF) m_count++;
		if (!m_body) begin
			if (c == 8'h0D || c == 8'h0A) begin
				if (m_nonempty) end_line();
				if (c == 8'h0A) begin
					if (m_lf < 3) m_lf++;
					if (m_lf >= 2) m_body = 1;
				end
			end else begin
				m_lf = 0;
				m_nonempty = 1;
				if (!m_nul) begin
					f = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
					if (c == 8'h00)
						m_nul = 1;
					else if (!m_colon) begin
						if (c == ":") begin
							m_colon = 1;
							if (m_pos != 14) m_cand &= 2'b10;
							if (m_pos != 10) m_cand &= 2'b01;
						end else begin
							if (!(m_pos < 14 && f == CLEN_S[m_pos])) m_cand &= 2'b10;
							if (!(m_pos < 10 && f == CONN_S[m_pos])) m_cand &= 2'b01;
							if (m_pos < 15) m_pos++;
						end
					end else
						value_char(f);
				end
			end
		end
		st.body = m_body;
		st.clen = m_clen;
		st.persist = m_keep && !m_close;
		st.count = m_count;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// ---- clock and reset ----
	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		byte_in = 0;
		restart = 0;
		out_ready = 0;
		clear_scanner();
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	// ---- input monitor: every accepted transfer feeds the model ----
	always @(posedge clk) begin
		status_t st;
		if (arst_n && in_valid && in_ready) begin
			scan_byte(byte_in, restart, st);
			// a hand-typed row stands in for the model's answer
			status_q.insert(status_q.size(), drive_typed ? drive_status : st);
		end
	end

	// ---- output side: random stalls, held off while calm ----
	always @(negedge clk) begin
		if (arst_n) out_ready <= calm || ($urandom_range(99) >= 20);
	end

	// ---- result check ----
	always @(posedge clk) begin
		status_t w;
		if (arst_n && out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				report_mismatch("output transfer count (unexpected transfer)", 1, 0);
			end else begin
				w = status_q.pop_front();
				if (in_body !== w.body) report_mismatch("in_body", in_body, w.body);
				if (length_value !== w.clen)
					report_mismatch("length_value", length_value, w.clen);
				if (persistent !== w.persist)
					report_mismatch("persistent", persistent, w.persist);
				if (bytes_seen !== w.count)
					report_mismatch("bytes_seen", bytes_seen, w.count);
			end
		end
	end

	// one input transfer; payload is set at the falling edge, held until taken
	task automatic send_byte(input logic [7:0] c, input bit rst, input bit typed,
			input status_t st);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 0;
			@(negedge clk);
		end
		drive_typed = typed;
		drive_status = st;
		in_valid <= 1;
		byte_in <= c;
		restart <= rst;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// ---- random response builder ----
	bit pending_restart;

	task automatic put(input logic [7:0] c);
		stream_q.insert(stream_q.size(), {pending_restart, c});
		pending_restart = 0;
	endtask

	task automatic put_str(input string s, input bit mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && c >= "a" && c <= "z" && $urandom_range(1)) c -= 8'd32;
			put(c);
		end
	endtask

	task automatic put_eol();
		case ($urandom_range(3))
			0: put(8'h0A);
			1: put(8'h0D);  // lone CR still ends the line
			default: begin
				put(8'h0D);
				put(8'h0A);
			end
		endcase
	endtask

	task automatic put_number();
		int n;
		repeat ($urandom_range(2)) begin
			case ($urandom_range(3))
				0: put(" ");
				1: put(8'h09);
				2: put(8'h0B);
				default: put(8'h0C);
			endcase
		end
		case ($urandom_range(3))
			0: put("-");
			1: put("+");
			default: ;
		endcase
		// mostly short values, some long enough to saturate, a few empty
		case ($urandom_range(9))
			0: n = 0;
			1, 2: n = $urandom_range(10, 13);
			default: n = $urandom_range(1, 6);
		endcase
		repeat (n) put(8'("0" + $urandom_range(9)));
		if ($urandom_range(4) == 0) put_str(" x9", 0);
	endtask

	task automatic put_line();
		int kind, len;
		kind = $urandom_range(10);
		lines_made++;
		case (kind)
			0, 1, 2: begin
				put_str("content-length", 1);
				put(":");
				put_number();
			end
			3, 4: begin
				put_str("connection:", 1);
				case ($urandom_range(6))
					0: put_str(" keep-alive", 1);
					1: put_str(" close", 1);
					2: put_str(" close, Keep-Alive", 1);
					3: put_str(" kkeep-alive", 1);
					4: put_str(" clos", 1);
					5: put_str("Upgrade, closeclose", 1);
					default: put_str(" keep-aliv", 1);
				endcase
			end
			5: begin  // unrelated header
				len = $urandom_range(1, 20);
				repeat (len) put(8'("a" + $urandom_range(25)));
				put(":");
				repeat ($urandom_range(8)) put(8'($urandom_range(8'h20, 8'h7E)));
			end
			6: repeat ($urandom_range(1, 10)) put(8'($urandom_range(8'h20, 8'h7E)));  // printable bytes, usually no colon
			7: begin  // near misses of the known names
				case ($urandom_range(3))
					0: put_str("content-lengthx: 12", 1);
					1: put_str("connectio: keep-alive", 1);
					2: put_str("content-length-extra-long: 7", 1);
					default: put_str("connection : close", 1);
				endcase
			end
			8: repeat ($urandom_range(1, 12)) put(8'($urandom_range(255)));  // raw noise
			default: begin  // NUL sometimes cuts the line short
				put_str($urandom_range(1) ? "content-length: 4" : "connection: close", 1);
				if ($urandom_range(1)) put(8'h00);
				put_str("2 keep-alive", 0);
			end
		endcase
		put_eol();
	endtask

	task automatic build_response();
		pending_restart = ($urandom_range(9) != 0);
		responses++;
		put_str("HTTP/1.1 200 OK", 0);
		put_eol();
		repeat ($urandom_range(1, 5)) put_line();
		// blank line ends the header, except in a few broken responses
		if ($urandom_range(9) != 0) begin
			put(8'h0A);
			if ($urandom_range(1)) put(8'h0A);
		end
		repeat ($urandom_range(6)) put(8'($urandom_range(255)));
	endtask

	// ---- stimulus ----
	row_t dir_rows[$];

	initial begin
		status_t    none;
		logic [8:0] it;
		int         rand_sent;
		none = '{0, 0, 0, 0};
		// corner bytes; after each restart or at header end the status is obvious
		dir_rows = '{
			'{"A",   1, 1, '{0, -1, 0, 1}},
			'{8'h00, 0, 0, none},
			'{8'hFF, 0, 0, none},
			'{8'h0D, 0, 0, none},
			'{8'h0A, 0, 0, none},
			'{8'h0A, 0, 1, '{1, -1, 0, 6}},
			'{8'h80, 0, 1, '{1, -1, 0, 7}},
			'{":",   1, 1, '{0, -1, 0, 1}},
			'{8'h0A, 0, 0, none},
			'{8'h0A, 1, 1, '{0, -1, 0, 1}},
			'{8'h0D, 0, 0, none},
			'{8'h0A, 0, 1, '{1, -1, 0, 3}},
			'{8'h7F, 1, 1, '{0, -1, 0, 1}},
			'{8'h00, 1, 1, '{0, -1, 0, 1}},
			'{8'h55, 0, 0, none},
			'{8'h2A, 0, 0, none},
			'{8'h0A, 0, 0, none},
			'{8'h0A, 0, 0, none}
		};
		wait (arst_n === 1'b1);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].ch, dir_rows[i].rst, dir_rows[i].typed, dir_rows[i].st);

		// random responses
		rand_sent = 0;
		while (rand_sent < 550) begin
			if (stream_q.size() == 0) build_response();
			it = stream_q.pop_front();
			calm = (rand_sent >= 200 && rand_sent < 300);
			// once, let the pipeline drain completely
			if (rand_sent == 400) begin
				@(negedge clk) in_valid <= 0;
				while (status_q.size() != 0) @(posedge clk);
			end
			send_byte(it[7:0], it[8], 0, none);
			rand_sent++;
		end
		@(negedge clk) in_valid <= 0;
		calm = 0;

		while (status_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d random responses (%0d header lines) plus corner bytes,",
			bytes_sent, responses, lines_made);
		$display("with random idling on both handshakes and one full drain.");
		if (errors == 0 && status_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ---- watchdog ----
	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", status_q.size());
		$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/hrs_pkg.sv
src/hrs_queue.sv
src/hrs_back.sv
src/hrs_front.sv
src/http_response_header_scanner.sv
dv/tb_http_response_header_scanner.sv
